>>> sv/pae_pkg.sv
`timescale 1ns / 1ps

package pae_pkg;

  localparam int unsigned LEVEL_W = 25;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned CFG_W   = 64;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 25'h100_0000;

  localparam logic [CFG_W-1:0] ATTACK_RESET  = 64'd3569438644979184009;
  localparam logic [CFG_W-1:0] DECAY_RESET   = 64'd2141775778696207801;
  localparam logic [CFG_W-1:0] SUSTAIN_RESET = 64'd9223512776490647552;
  localparam logic [CFG_W-1:0] RELEASE_RESET = 64'd3569438644979184009;

  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_OFF     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] lane;
    logic [1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               running;
    logic [2:0]         lane_out;
  } out_item_t;

  // settings of one channel, picked out of the four config words
  typedef struct packed {
    logic [RATE_W-1:0] attack;
    logic [RATE_W-1:0] decay;
    logic [RATE_W-1:0] sustain;
    logic [RATE_W-1:0] rel;
  } chan_cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEVEL_W-1:0] level;
  } lane_st_t;

endpackage

>>> sv/pae_cfg_regs.sv
`timescale 1ns / 1ps

module pae_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [pae_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [1:0]               chan_sel,
  output pae_pkg::chan_cfg_t       chan_cfg
);
  import pae_pkg::*;

  logic [CFG_W-1:0] attack_r;
  logic [CFG_W-1:0] decay_r;
  logic [CFG_W-1:0] sustain_r;
  logic [CFG_W-1:0] release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RESET;
      decay_r   <= DECAY_RESET;
      sustain_r <= SUSTAIN_RESET;
      release_r <= RELEASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ATTACK:  attack_r  <= cfg_wdata;
        CFG_DECAY:   decay_r   <= cfg_wdata;
        CFG_SUSTAIN: sustain_r <= cfg_wdata;
        CFG_RELEASE: release_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // channel c sits in bits 16c+15..16c of each word
  always_comb begin
    chan_cfg.attack  = attack_r[RATE_W*chan_sel +: RATE_W];
    chan_cfg.decay   = decay_r[RATE_W*chan_sel +: RATE_W];
    chan_cfg.sustain = sustain_r[RATE_W*chan_sel +: RATE_W];
    chan_cfg.rel     = release_r[RATE_W*chan_sel +: RATE_W];
  end

endmodule

>>> sv/pae_lane_step.sv
`timescale 1ns / 1ps

module pae_lane_step (
  input  pae_pkg::cmd_t      cmd,
  input  pae_pkg::lane_st_t  cur,
  input  pae_pkg::chan_cfg_t cfg,
  output pae_pkg::lane_st_t  nxt
);
  import pae_pkg::*;

  logic [LEVEL_W-1:0] sus;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] lv;
  logic [LEVEL_W-1:0] diff;
  phase_t             ph;

  always_comb begin
    sus  = {1'b0, cfg.sustain, 8'b0};
    ph   = cur.phase;
    lv   = cur.level;
    sum  = '0;
    diff = '0;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        case (ph)
          PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE: begin
            if (ph == PH_ATTACK) begin
              sum = {1'b0, lv} + {{(LEVEL_W+1-RATE_W){1'b0}}, cfg.attack};
              if (cfg.attack == '0 || lv >= FULL_SCALE) begin
                lv = FULL_SCALE;
                ph = PH_DECAY;
              end else if (sum > {1'b0, FULL_SCALE}) begin
                lv = FULL_SCALE;
              end else begin
                lv = sum[LEVEL_W-1:0];
              end
            end
            // attack may fall through into decay in the same sample
            if (ph == PH_DECAY) begin
              diff = lv - sus;
              if (cfg.decay == '0 || lv <= sus) begin
                lv = sus;
                ph = PH_SUSTAIN;
              end else if (diff > {{(LEVEL_W-RATE_W){1'b0}}, cfg.decay}) begin
                lv = lv - {{(LEVEL_W-RATE_W){1'b0}}, cfg.decay};
              end else begin
                lv = sus;
              end
            end
            if (ph == PH_RELEASE) begin
              if (cfg.rel == '0 || lv == '0) begin
                lv = '0;
                ph = PH_OFF;
              end else if (lv > {{(LEVEL_W-RATE_W){1'b0}}, cfg.rel}) begin
                lv = lv - {{(LEVEL_W-RATE_W){1'b0}}, cfg.rel};
              end else begin
                lv = '0;
              end
            end
          end
          default: begin
            ph = PH_OFF;
            lv = '0;
          end
        endcase
      end
      CMD_TRIGGER: ph = PH_ATTACK;
      CMD_RELEASE: ph = PH_RELEASE;
      default:     ph = PH_OFF;
    endcase
    nxt.phase = ph;
    nxt.level = lv;
  end

endmodule

>>> sv/polyphonic_adsr_envelope.sv
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  in_item_t  (command, lane, channel)
// out_     output     out_valid/out_stall out_item_t (level, running, lane_out)
// cfg_     input      cfg_we             cfg_addr, cfg_wdata (64 bits)
//
// one item per cycle sustained while out_stall is low; an accepted item passes
// through the input register, then the result register, before it is presented
// the lane update (add, compare, clamp) sits between the input register
// and the result register, so a command on the same lane may follow at once
// reset clears all lanes to off at level zero and loads the default settings
// a stall on the result side holds the result register, then the input
// register, then raises in_stall

module polyphonic_adsr_envelope #(
  parameter int LANES         = 8,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pae_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pae_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [pae_pkg::CFG_W-1:0] cfg_wdata
);
  import pae_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  in_item_t           a_r;
  logic               a_valid_r;
  out_item_t          out_r;
  logic               out_valid_r;

  phase_t             phase_r [LANES];
  logic [LEVEL_W-1:0] level_r [LANES];
  logic [1:0]         chan_r  [LANES];

  logic               b_ready;
  logic               a_ready;
  logic               fire_ab;
  logic [LW-1:0]      idx;
  logic               lane_ok;
  logic [1:0]         ch_sat;
  chan_cfg_t          chan_cfg;
  lane_st_t           cur_st;
  lane_st_t           nxt_st;
  out_item_t          out_nxt;

  assign b_ready  = !out_valid_r || !out_stall;
  assign a_ready  = !a_valid_r || b_ready;
  assign fire_ab  = a_valid_r && b_ready;
  assign in_stall = !a_ready;

  assign idx     = LW'(a_r.lane);
  assign lane_ok = 32'(a_r.lane) < LANES;
  assign ch_sat  = (32'(a_r.channel) >= CHANNEL_COUNT) ? 2'(CHANNEL_COUNT - 1) : a_r.channel;

  assign cur_st.phase = phase_r[idx];
  assign cur_st.level = level_r[idx];

  pae_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .chan_sel (chan_r[idx]),
    .chan_cfg (chan_cfg)
  );

  pae_lane_step u_step (
    .cmd(cmd_t'(a_r.command)),
    .cur(cur_st),
    .cfg(chan_cfg),
    .nxt(nxt_st)
  );

  always_comb begin
    out_nxt.lane_out = a_r.lane;
    if (lane_ok) begin
      out_nxt.level   = nxt_st.level;
      out_nxt.running = (nxt_st.phase != PH_OFF);
    end else begin
      out_nxt.level   = '0;
      out_nxt.running = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_r <= in_data;
    end
    if (fire_ab) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        phase_r[i] <= PH_OFF;
        level_r[i] <= '0;
        chan_r[i]  <= '0;
      end
    end else if (fire_ab && lane_ok) begin
      phase_r[idx] <= nxt_st.phase;
      level_r[idx] <= nxt_st.level;
      if (cmd_t'(a_r.command) == CMD_TRIGGER) begin
        chan_r[idx] <= ch_sat;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.level <= FULL_SCALE)
    else $error("level above full scale");

  a_bad_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && 32'(out_r.lane_out) >= LANES) |-> (out_r.level == '0 && !out_r.running))
    else $error("out-of-range lane reported activity");

  a_trigger_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_ab && lane_ok && cmd_t'(a_r.command) == CMD_TRIGGER) |=> out_r.running)
    else $error("trigger did not start the lane");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_ab && cmd_t'(a_r.command) == CMD_STOP) |=> !out_r.running)
    else $error("stop left the lane running");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule
